### design/dacp_pkg.sv
// Package for the distance and centering PID drive.
// Holds the field widths, the loop constants, the channel gains and the shared types.
// No dependencies.
package dacp_pkg;

	localparam int DistW    = 13;
	localparam int ProxW    = 12;
	localparam int TgtW     = 11;
	localparam int LimW     = 12;
	localparam int SpdW     = 16;
	localparam int GainW    = 12;
	localparam int FwdW     = 13;
	localparam int ChanOutW = 13;
	localparam int NChan    = 3;
	localparam int NProx    = 6;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 12;
	localparam int InDataW  = 88;
	localparam int OutDataW = 32;

	// distance loop, gains in Q.12
	localparam int DistKpQ12   = 50 * 4096;
	localparam int DistKiQ12   = 1188;
	localparam int DistIntMax  = 500;
	localparam int DistBand    = 5;
	// proximity channels
	localparam int ProxIntMax  = 100;
	localparam int ProxBand    = 15;

	localparam logic [GainW-1:0] KP_Q12 [NChan] = '{12'd410, 12'd2867, 12'd2458};
	localparam logic [GainW-1:0] KI_Q12 [NChan] = '{12'd205, 12'd123, 12'd287};
	localparam logic [GainW-1:0] KD_Q12 [NChan] = '{12'd287, 12'd164, 12'd123};

	localparam logic [TgtW-1:0] TARGET_RESET = 11'd100;
	localparam logic [LimW-1:0] LIMIT_RESET  = 12'd1100;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TARGET = 2'd0,
		CFG_LIMIT  = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [TgtW-1:0] target;
		logic [LimW-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic                        halt;
		logic [NProx-1:0][ProxW-1:0] prox;
		logic [DistW-1:0]            dist_mm;
	} item_t;

endpackage

### design/dacp_fwd.sv
// Forward speed PI loop on distance minus target, with dead band, integral clamp
// and output saturation. Owns the distance integral. Depends on dacp_pkg.
module dacp_fwd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dacp_pkg::cfg_t                cfg,
	input  logic [dacp_pkg::DistW-1:0]    dist_mm,
	input  logic                          upd,
	output logic signed [dacp_pkg::FwdW-1:0] fwd
);
	import dacp_pkg::*;

	logic signed [9:0]  integ_q;
	logic signed [13:0] e;
	logic signed [14:0] s;
	logic               band;
	logic signed [31:0] acc;
	logic        [31:0] mag;
	logic signed [20:0] sp;
	logic signed [20:0] sat;
	logic        [13:0] lim3;
	logic signed [9:0]  integ_nxt;

	always_comb begin
		e    = $signed({1'b0, dist_mm}) - $signed({3'b000, cfg.target});
		band = (e > -14'(DistBand)) && (e < 14'(DistBand));
		s    = $signed({e[13], e}) + $signed({{5{integ_q[9]}}, integ_q});
		acc  = ($signed({{18{e[13]}}, e}) * 32'(DistKpQ12))
		     + ($signed({{17{s[14]}}, s}) * 32'(DistKiQ12));
		// truncate toward zero
		mag  = acc[31] ? 32'(-acc) : 32'(acc);
		sp   = acc[31] ? -$signed({1'b0, mag[31:12]}) : $signed({1'b0, mag[31:12]});
		lim3 = {1'b0, cfg.limit, 1'b0} + {2'b00, cfg.limit};
		sat  = $signed({9'd0, lim3[13:2]});
		if (band) begin
			fwd = '0;
		end else if (sp > sat) begin
			fwd = sat[FwdW-1:0];
		end else if (sp < -sat) begin
			fwd = FwdW'(-sat);
		end else begin
			fwd = sp[FwdW-1:0];
		end
		if (s > 15'(DistIntMax)) begin
			integ_nxt = 10'(DistIntMax);
		end else if (s < -15'(DistIntMax)) begin
			integ_nxt = -10'(DistIntMax);
		end else begin
			integ_nxt = s[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (upd && !band) begin
			integ_q <= integ_nxt;
		end
	end

endmodule

### design/dacp_chan.sv
// One proximity PID channel: difference, clamped integral, noise band and
// derivative on its own previous error. Depends on dacp_pkg.
module dacp_chan (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [dacp_pkg::ProxW-1:0]         a,
	input  logic [dacp_pkg::ProxW-1:0]         b,
	input  logic [dacp_pkg::GainW-1:0]         kp,
	input  logic [dacp_pkg::GainW-1:0]         ki,
	input  logic [dacp_pkg::GainW-1:0]         kd,
	input  logic                               upd,
	output logic signed [dacp_pkg::ChanOutW-1:0] y
);
	import dacp_pkg::*;

	logic signed [7:0]  integ_q;
	logic signed [12:0] prev_q;
	logic signed [12:0] d;
	logic signed [13:0] isum;
	logic signed [7:0]  integ_nxt;
	logic signed [12:0] dn;
	logic signed [13:0] diff;
	logic signed [25:0] acc;
	logic        [25:0] mag;

	always_comb begin
		d    = $signed({1'b0, a}) - $signed({1'b0, b});
		isum = $signed({d[12], d}) + $signed({{6{integ_q[7]}}, integ_q});
		if (isum > 14'(ProxIntMax)) begin
			integ_nxt = 8'(ProxIntMax);
		end else if (isum < -14'(ProxIntMax)) begin
			integ_nxt = -8'(ProxIntMax);
		end else begin
			integ_nxt = isum[7:0];
		end
		// noise band applies after the integration
		dn   = ((d > -13'(ProxBand)) && (d < 13'(ProxBand))) ? '0 : d;
		diff = $signed({dn[12], dn}) - $signed({prev_q[12], prev_q});
		acc  = ($signed({{13{dn[12]}}, dn}) * $signed({14'd0, kp}))
		     + ($signed({{18{integ_nxt[7]}}, integ_nxt}) * $signed({14'd0, ki}))
		     + ($signed({{12{diff[13]}}, diff}) * $signed({14'd0, kd}));
		mag  = acc[25] ? 26'(-acc) : 26'(acc);
		y    = acc[25] ? -$signed(mag[24:12]) : $signed(mag[24:12]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (upd) begin
			integ_q <= integ_nxt;
			prev_q  <= dn;
		end
	end

endmodule

### design/distance_and_centering_pid_drive.sv
// Distance and centering PID drive, top level.
// Holds the input and result registers, the configuration registers and the
// forward loop and proximity channels. Depends on dacp_pkg, dacp_fwd, dacp_chan.
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one sensor tick per item; s_tuser
//   is the halt flag, which zeroes both wheel speeds and leaves all loop state
//   untouched. m_tvalid/m_tready/m_tdata carry the left and right wheel speeds.
//   cfg_we/cfg_addr/cfg_wdata write target_distance (index 0) and speed_limit
//   (index 1); write them only while no item is in flight.
//   An accepted item is held in the input register, and its result is loaded
//   into the result register that drives m_tdata once the output is free.
//   Throughput: one item per cycle while the receiver takes results. The whole
//   control step, integrals and previous errors included, is combinational
//   between the input register and the result register, so each item sees the
//   state left by the one before. Reset clears all integrals and previous errors,
//   drops both valid flags and loads target 100 and limit 1100. When the receiver
//   stalls, the result register holds and the input register keeps taking one more
//   item; then s_tready falls until the result is taken.
module distance_and_centering_pid_drive (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// distance_mm, prox_left, prox_right, prox_front_left, prox_front_right,
	// prox_back_left, prox_back_right, zero fill
	input  logic [dacp_pkg::InDataW-1:0]     s_tdata,
	// halt
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// left_speed, right_speed
	output logic [dacp_pkg::OutDataW-1:0]    m_tdata,
	input  logic                             cfg_we,
	input  logic [dacp_pkg::CfgIdxW-1:0]     cfg_addr,
	input  logic [dacp_pkg::CfgDataW-1:0]    cfg_wdata
);
	import dacp_pkg::*;

	item_t                         item_s1;
	logic                          v_s1;
	logic [OutDataW-1:0]           res_s2;
	logic                          v_s2;
	cfg_t                          cfg_q;
	logic                          adv;
	logic                          upd;
	logic signed [FwdW-1:0]        fwd;
	logic signed [ChanOutW-1:0]    chan_y [NChan];
	logic signed [14:0]            turn;
	logic signed [SpdW-1:0]        left_spd;
	logic signed [SpdW-1:0]        right_spd;

	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign upd      = adv && !item_s1.halt;
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = v_s2;
	assign m_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target <= TARGET_RESET;
			cfg_q.limit  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_TARGET: cfg_q.target <= cfg_wdata[TgtW-1:0];
				CFG_LIMIT:  cfg_q.limit  <= cfg_wdata[LimW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.dist_mm <= s_tdata[DistW-1:0];
			item_s1.prox    <= s_tdata[DistW+NProx*ProxW-1:DistW];
			item_s1.halt    <= s_tuser;
		end
		if (adv) begin
			res_s2 <= {right_spd, left_spd};
		end
	end

	dacp_fwd u_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.dist_mm (item_s1.dist_mm),
		.upd     (upd),
		.fwd     (fwd)
	);

	for (genvar i = 0; i < NChan; i++) begin : g_chan
		dacp_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.a      (item_s1.prox[2*i]),
			.b      (item_s1.prox[2*i+1]),
			.kp     (KP_Q12[i]),
			.ki     (KI_Q12[i]),
			.kd     (KD_Q12[i]),
			.upd    (upd),
			.y      (chan_y[i])
		);
	end

	always_comb begin
		turn = $signed({{2{chan_y[0][12]}}, chan_y[0]})
		     + $signed({{2{chan_y[1][12]}}, chan_y[1]})
		     + $signed({{2{chan_y[2][12]}}, chan_y[2]});
		if (item_s1.halt) begin
			left_spd  = '0;
			right_spd = '0;
		end else begin
			left_spd  = $signed({{3{fwd[12]}}, fwd}) + $signed({turn[14], turn});
			right_spd = $signed({{3{fwd[12]}}, fwd}) - $signed({turn[14], turn});
		end
	end

endmodule

### design/dacp_chk.sv
// Port-level checks for the distance and centering PID drive, bound to the top level.
// Depends on distance_and_centering_pid_drive.
module dacp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	logic signed [16:0] wheel_sum;

	assign wheel_sum = $signed({m_tdata[15], m_tdata[15:0]})
	                 + $signed({m_tdata[31], m_tdata[31:16]});

	// reset empties the result register
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// left and right differ by twice the turn term, so their low bits agree
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[0] == m_tdata[16])
		else $error("wheel speeds not split symmetrically");

	// the sum is twice the saturated forward speed, or zero under halt
	a_fwd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (wheel_sum <= 17'sd6142) && (wheel_sum >= -17'sd6142))
		else $error("forward speed beyond saturation");

endmodule

bind distance_and_centering_pid_drive dacp_chk u_dacp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
